// ===== src/lsbs_pkg.sv =====
// Shared types and constants of the laser scan breakpoint segmenter.
`timescale 1ns / 1ps

package lsbs_pkg;

    localparam int RANGE_W      = 16;
    localparam int COORD_W      = 16;
    localparam int CLUSTER_W    = 8;
    localparam int NUM_IDS      = 255;
    localparam int FRAC_W       = 16;
    localparam int GAIN_W       = 16;
    localparam int MIN_SIZE_W   = 5;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int MUL_A_W      = 32;
    localparam int MUL_B_W      = 16;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

    localparam int DEF_MAX_MIN_SIZE = 16;
    localparam int DEF_INDEX_BITS   = 12;

    localparam logic [GAIN_W-1:0]     GAIN_RESET     = 16'd2859;
    localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_RESET = 5'd5;

    localparam logic [CFG_ADDR_W-1:0] REG_BREAKPOINT_GAIN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_CLUSTER_SIZE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DECIDE,
        ST_DRAIN,
        ST_EMIT
    } lsbs_state_t;

endpackage

// ===== src/lsbs_mul.sv =====
// Shared multiplier with a registered product.
`timescale 1ns / 1ps

module lsbs_mul (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [lsbs_pkg::MUL_A_W-1:0] a,
    input  logic [lsbs_pkg::MUL_B_W-1:0] b,
    output logic [lsbs_pkg::MUL_P_W-1:0] p
);

    logic [lsbs_pkg::MUL_P_W-1:0] p_reg;
    logic [lsbs_pkg::MUL_P_W-1:0] p_next;

    assign p_next = lsbs_pkg::MUL_P_W'(a) * lsbs_pkg::MUL_P_W'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== src/lsbs_pend_mem.sv =====
// Store for the points of a cluster that has not yet reached its minimum size.
`timescale 1ns / 1ps

module lsbs_pend_mem #(
    parameter int DEPTH = 15,
    parameter int AW    = 4,
    parameter int DW    = 44
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/laser_scan_breakpoint_segmenter.sv =====
// Top level of the laser scan breakpoint segmenter: sequencer and datapath.
//
//  Channel | Dir | Signals                  | Contents (lowest bits first)
//  s_      | in  | tvalid tready tdata tuser| beam_index, range_mm, point_x, point_y; scan_start
//  m_      | out | tvalid tready tdata tlast| out_x, out_y, out_index, cluster_id; last_of_run
//  cfg_    | in  | we addr wdata            | 0 breakpoint_gain, 1 min_cluster_size
//
// An input beat passes through acceptance, two passes through the one shared
// multiplier, and the decision, in that order. Each result beat is then loaded in
// turn, the buffered points of the burst first and the current one last.
// The single read port of the pending store paces the burst at one beat a cycle unless stalled.
// Reset is synchronous and active low; the pending store needs no clearing pass.
// A stalled result beat holds the sequencer until the output register is free.
`timescale 1ns / 1ps

module laser_scan_breakpoint_segmenter #(
    parameter int MAX_MIN_SIZE = lsbs_pkg::DEF_MAX_MIN_SIZE,
    parameter int INDEX_BITS   = lsbs_pkg::DEF_INDEX_BITS,
    localparam int IN_W        = INDEX_BITS + lsbs_pkg::RANGE_W + 2 * lsbs_pkg::COORD_W,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 2 * lsbs_pkg::COORD_W + INDEX_BITS + lsbs_pkg::CLUSTER_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Slave side: tdata = beam_index, range_mm, point_x, point_y; tuser = scan_start.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_TDATA_W-1:0]             s_tdata,
    input  logic                              s_tuser,
    // Master side: tdata = out_x, out_y, out_index, cluster_id; tlast = last_of_run.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_TDATA_W-1:0]            m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [lsbs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lsbs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int RW         = $clog2(MAX_MIN_SIZE + 1);
    localparam int SW         = (RW > lsbs_pkg::MIN_SIZE_W) ? RW : lsbs_pkg::MIN_SIZE_W;
    localparam int PEND_DEPTH = (MAX_MIN_SIZE > 1) ? MAX_MIN_SIZE - 1 : 1;
    localparam int AW         = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int PW         = 2 * lsbs_pkg::COORD_W + INDEX_BITS;
    localparam int CW         = lsbs_pkg::CLUSTER_W;
    localparam int RNG_W      = lsbs_pkg::RANGE_W;
    localparam int XY_W       = lsbs_pkg::COORD_W;

    lsbs_pkg::lsbs_state_t state_reg, state_next;

    logic [lsbs_pkg::GAIN_W-1:0]     gain_reg;
    logic [lsbs_pkg::MIN_SIZE_W-1:0] min_size_reg;

    logic                  start_in_reg;
    logic [INDEX_BITS-1:0] idx_in_reg;
    logic [RNG_W-1:0]      rng_in_reg;
    logic [XY_W-1:0]       x_in_reg;
    logic [XY_W-1:0]       y_in_reg;

    logic [RNG_W-1:0]      prev_range_reg;
    logic [INDEX_BITS-1:0] prev_index_reg;
    logic [CW-1:0]         cluster_reg;
    logic [RW-1:0]         run_reg;
    logic [RW-1:0]         drain_cnt_reg;
    logic [RW-1:0]         drain_total_reg;

    logic                  m_tvalid_reg;
    logic                  m_tlast_reg;
    logic [OUT_W-1:0]      m_data_reg;

    logic [INDEX_BITS-1:0] step;
    logic [RNG_W-1:0]      diff;
    logic [lsbs_pkg::MUL_P_W-1:0] cmp_lhs;
    logic [lsbs_pkg::MUL_P_W-1:0] mul_p;
    logic [lsbs_pkg::MUL_A_W-1:0] mul_a;
    logic [lsbs_pkg::MUL_B_W-1:0] mul_b;
    logic                  mul_en;
    logic                  brk;
    logic [RW-1:0]         run_eff;
    logic [CW-1:0]         cluster_inc;
    logic [CW-1:0]         cluster_eff;
    logic [SW-1:0]         msz_wide;
    logic [RW-1:0]         msz;
    logic                  full;
    logic                  hit;
    logic                  slot_free;
    logic                  last_drain;

    logic                  pend_wr_en;
    logic                  pend_rd_en;
    logic [AW-1:0]         pend_rd_addr;
    logic [PW-1:0]         pend_rd_data;
    logic                  out_load;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= lsbs_pkg::GAIN_RESET;
            min_size_reg <= lsbs_pkg::MIN_SIZE_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == lsbs_pkg::REG_BREAKPOINT_GAIN) begin
                gain_reg <= cfg_wdata;
            end else if (cfg_addr == lsbs_pkg::REG_MIN_CLUSTER_SIZE) begin
                min_size_reg <= cfg_wdata[lsbs_pkg::MIN_SIZE_W-1:0];
            end
        end
    end

    always_comb begin
        if (min_size_reg == '0) begin
            msz_wide = SW'(1);
        end else if (SW'(min_size_reg) > SW'(MAX_MIN_SIZE)) begin
            msz_wide = SW'(MAX_MIN_SIZE);
        end else begin
            msz_wide = SW'(min_size_reg);
        end
    end
    assign msz = msz_wide[RW-1:0];

    // Breakpoint test operands.
    assign step = (idx_in_reg >= prev_index_reg) ? idx_in_reg - prev_index_reg
                                                 : prev_index_reg - idx_in_reg;
    assign diff = (rng_in_reg >= prev_range_reg) ? rng_in_reg - prev_range_reg
                                                 : prev_range_reg - rng_in_reg;
    assign cmp_lhs = lsbs_pkg::MUL_P_W'({diff, {lsbs_pkg::FRAC_W{1'b0}}});

    assign mul_en = (state_reg == lsbs_pkg::ST_MUL1) || (state_reg == lsbs_pkg::ST_MUL2);
    assign mul_a  = (state_reg == lsbs_pkg::ST_MUL2) ? mul_p[lsbs_pkg::MUL_A_W-1:0]
                                                     : lsbs_pkg::MUL_A_W'(gain_reg);
    assign mul_b  = (state_reg == lsbs_pkg::ST_MUL2) ? lsbs_pkg::MUL_B_W'(step)
                                                     : lsbs_pkg::MUL_B_W'(prev_range_reg);

    lsbs_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign brk         = !(cmp_lhs < mul_p);
    assign cluster_inc = (cluster_reg == CW'(lsbs_pkg::NUM_IDS - 1)) ? '0
                                                                     : cluster_reg + CW'(1);
    assign run_eff     = (start_in_reg || brk) ? '0 : run_reg;
    assign cluster_eff = start_in_reg ? '0 : (brk ? cluster_inc : cluster_reg);
    assign full        = run_eff >= msz;
    assign hit         = (run_eff + RW'(1)) == msz;
    assign slot_free   = !m_tvalid_reg || m_tready;
    assign last_drain  = (drain_cnt_reg + RW'(1)) == drain_total_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsbs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = lsbs_pkg::ST_MUL1;
                end
            end
            lsbs_pkg::ST_MUL1: begin
                state_next = lsbs_pkg::ST_MUL2;
            end
            lsbs_pkg::ST_MUL2: begin
                state_next = lsbs_pkg::ST_DECIDE;
            end
            lsbs_pkg::ST_DECIDE: begin
                priority if (full) begin
                    state_next = lsbs_pkg::ST_EMIT;
                end else if (hit) begin
                    state_next = (run_eff != '0) ? lsbs_pkg::ST_DRAIN : lsbs_pkg::ST_EMIT;
                end else begin
                    state_next = lsbs_pkg::ST_IDLE;
                end
            end
            lsbs_pkg::ST_DRAIN: begin
                if (slot_free && last_drain) begin
                    state_next = lsbs_pkg::ST_EMIT;
                end
            end
            lsbs_pkg::ST_EMIT: begin
                if (slot_free) begin
                    state_next = lsbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready     = 1'b0;
        pend_wr_en   = 1'b0;
        pend_rd_en   = 1'b0;
        pend_rd_addr = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            lsbs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            lsbs_pkg::ST_DECIDE: begin
                pend_wr_en = !full && !hit;
                pend_rd_en = !full && hit && (run_eff != '0);
            end
            lsbs_pkg::ST_DRAIN: begin
                out_load     = slot_free;
                pend_rd_en   = slot_free && !last_drain;
                pend_rd_addr = AW'(drain_cnt_reg + RW'(1));
            end
            lsbs_pkg::ST_EMIT: begin
                out_load = slot_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    lsbs_pend_mem #(
        .DEPTH (PEND_DEPTH),
        .AW    (AW),
        .DW    (PW)
    ) u_pend (
        .aclk    (aclk),
        .wr_en   (pend_wr_en),
        .wr_addr (run_eff[AW-1:0]),
        .wr_data ({idx_in_reg, y_in_reg, x_in_reg}),
        .rd_en   (pend_rd_en),
        .rd_addr (pend_rd_addr),
        .rd_data (pend_rd_data)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lsbs_pkg::ST_IDLE;
            prev_range_reg  <= '0;
            prev_index_reg  <= '0;
            cluster_reg     <= '0;
            run_reg         <= '0;
            drain_cnt_reg   <= '0;
            drain_total_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == lsbs_pkg::ST_DECIDE) begin
                prev_range_reg  <= rng_in_reg;
                prev_index_reg  <= idx_in_reg;
                cluster_reg     <= cluster_eff;
                drain_total_reg <= run_eff;
                drain_cnt_reg   <= '0;
                priority if (full) begin
                    run_reg <= run_eff;
                end else if (hit) begin
                    run_reg <= msz;
                end else begin
                    run_reg <= run_eff + RW'(1);
                end
            end
            if (state_reg == lsbs_pkg::ST_DRAIN && slot_free) begin
                drain_cnt_reg <= drain_cnt_reg + RW'(1);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            start_in_reg <= s_tuser;
            idx_in_reg   <= s_tdata[INDEX_BITS-1:0];
            rng_in_reg   <= s_tdata[INDEX_BITS +: RNG_W];
            x_in_reg     <= s_tdata[INDEX_BITS + RNG_W +: XY_W];
            y_in_reg     <= s_tdata[INDEX_BITS + RNG_W + XY_W +: XY_W];
        end
        if (out_load) begin
            if (state_reg == lsbs_pkg::ST_DRAIN) begin
                m_data_reg  <= {cluster_reg, pend_rd_data};
                m_tlast_reg <= 1'b0;
            end else begin
                m_data_reg  <= {cluster_reg, idx_in_reg, y_in_reg, x_in_reg};
                m_tlast_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = OUT_TDATA_W'(m_data_reg);

    a_accept_starts_mul : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == lsbs_pkg::ST_MUL1))
        else $error("accepted beat did not start the multiplier passes");

    a_run_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= RW'(MAX_MIN_SIZE))
        else $error("run length exceeds the largest minimum size");

    a_cluster_wraps : assert property (@(posedge aclk) disable iff (!aresetn)
        cluster_reg < CW'(lsbs_pkg::NUM_IDS))
        else $error("cluster number out of range");

    a_drain_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsbs_pkg::ST_DRAIN) |-> (drain_cnt_reg < drain_total_reg))
        else $error("burst read past the held points");

    a_no_load_over_pending : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !out_load)
        else $error("result register overwritten while stalled");

endmodule

// ===== tb/tb_laser_scan_breakpoint_segmenter.sv =====
// Self-checking testbench of the laser scan breakpoint segmenter: stream driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_laser_scan_breakpoint_segmenter;

    localparam int MAX_MIN_SIZE   = lsbs_pkg::DEF_MAX_MIN_SIZE;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [lsbs_pkg::CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [lsbs_pkg::CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic        scan_start;
        logic [11:0] beam;
        logic [15:0] rng_mm;
        logic [15:0] x;
        logic [15:0] y;
    } scan_point_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [11:0] beam;
        logic [7:0]  cluster;
        logic        is_last;
    } cluster_point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [lsbs_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [lsbs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    scan_point_t    beam_queue[$];
    cluster_point_t emitted_points_q[$];
    int items_queued = 0;
    int beats_accepted = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int hold_count = 0;

    // Shadow configuration and segmentation state.
    logic [15:0] cfg_gain = lsbs_pkg::GAIN_RESET;
    logic [4:0]  cfg_min_size = lsbs_pkg::MIN_SIZE_RESET;
    logic [15:0] seg_prev_range = '0;
    logic [11:0] seg_prev_beam = '0;
    logic [7:0]  seg_cluster = '0;
    int          seg_run_len = 0;
    logic [15:0] held_x[MAX_MIN_SIZE];
    logic [15:0] held_y[MAX_MIN_SIZE];
    logic [11:0] held_beam[MAX_MIN_SIZE];

    always #5 aclk = ~aclk;

    laser_scan_breakpoint_segmenter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    task automatic push_emitted(input logic [15:0] x, input logic [15:0] y,
                                input logic [11:0] beam, input logic is_last);
        cluster_point_t r;
        r.x = x;
        r.y = y;
        r.beam = beam;
        r.cluster = seg_cluster;
        r.is_last = is_last;
        emitted_points_q.insert(emitted_points_q.size(), r);
    endtask

    task automatic segment_point(input scan_point_t p);
        int          eff_size;
        logic [63:0] step;
        logic [63:0] diff;
        logic [63:0] lim;
        eff_size = (cfg_min_size == 0) ? 1 :
                   (cfg_min_size > MAX_MIN_SIZE) ? MAX_MIN_SIZE : int'(cfg_min_size);
        if (p.scan_start) begin
            seg_cluster = '0;
            seg_run_len = 0;
        end else begin
            step = (p.beam >= seg_prev_beam) ? 64'(p.beam - seg_prev_beam)
                                             : 64'(seg_prev_beam - p.beam);
            diff = (p.rng_mm >= seg_prev_range) ? 64'(p.rng_mm - seg_prev_range)
                                                : 64'(seg_prev_range - p.rng_mm);
            lim = 64'(cfg_gain) * step * 64'(seg_prev_range);
            if (!((diff << 16) < lim)) begin
                seg_cluster = (seg_cluster == 8'(lsbs_pkg::NUM_IDS - 1)) ? 8'd0
                                                                        : seg_cluster + 8'd1;
                seg_run_len = 0;
            end
        end
        if (seg_run_len >= eff_size) begin
            push_emitted(p.x, p.y, p.beam, 1'b1);
        end else if (seg_run_len + 1 == eff_size) begin
            for (int k = 0; k < seg_run_len; k++) begin
                push_emitted(held_x[k], held_y[k], held_beam[k], 1'b0);
            end
            push_emitted(p.x, p.y, p.beam, 1'b1);
            seg_run_len = eff_size;
        end else begin
            held_x[seg_run_len] = p.x;
            held_y[seg_run_len] = p.y;
            held_beam[seg_run_len] = p.beam;
            seg_run_len++;
        end
        seg_prev_range = p.rng_mm;
        seg_prev_beam = p.beam;
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 10) begin
            $display("%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Driver: a beat leaves when accepted, then the next pending point may be offered.
    always @(posedge aclk) begin : driver
        scan_point_t offered;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                segment_point(offered);
                beats_accepted++;
            end
            if (beam_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered = beam_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, offered.y, offered.x, offered.rng_mm, offered.beam};
                s_tuser <= offered.scan_start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : receiver
        if (hold_request && !hold_done) begin
            m_tready <= 1'b0;
            if (hold_count == HOLD_CYCLES) begin
                hold_done <= 1'b1;
            end else begin
                hold_count <= hold_count + 1;
            end
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        cluster_point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (emitted_points_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat tdata=%h tlast=%b",
                                          m_tdata, m_tlast));
            end else begin
                want = emitted_points_q.pop_front();
                if (m_tdata[15:0] !== want.x || m_tdata[31:16] !== want.y ||
                    m_tdata[43:32] !== want.beam || m_tdata[51:44] !== want.cluster ||
                    m_tlast !== want.is_last) begin
                    report_mismatch($sformatf(
                        {"expected x=%h y=%h index=%h cluster=%0d last=%b, ",
                         "got x=%h y=%h index=%h cluster=%0d last=%b"},
                        want.x, want.y, want.beam, want.cluster, want.is_last,
                        m_tdata[15:0], m_tdata[31:16], m_tdata[43:32], m_tdata[51:44],
                        m_tlast));
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_point(input logic scan_start, input logic [11:0] beam,
                             input logic [15:0] rng_mm, input logic [15:0] x,
                             input logic [15:0] y);
        scan_point_t p;
        p.scan_start = scan_start;
        p.beam = beam;
        p.rng_mm = rng_mm;
        p.x = x;
        p.y = y;
        beam_queue.insert(beam_queue.size(), p);
        items_queued++;
    endtask

    task automatic add_noise_point(input logic scan_start);
        add_point(scan_start, 12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // A run of points whose range changes stay mostly under the breakpoint threshold.
    task automatic add_cluster_run(input int len);
        logic [11:0] beam;
        int unsigned rng;
        int unsigned step;
        bit          upward;
        logic [63:0] allow;
        int unsigned delta;
        beam = 12'($urandom);
        rng = $urandom_range(200, 65535);
        step = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
        upward = $urandom_range(1);
        add_point($urandom_range(9) == 0, beam, 16'(rng), 16'($urandom), 16'($urandom));
        for (int k = 1; k < len; k++) begin
            beam = upward ? beam + 12'(step) : beam - 12'(step);
            allow = (64'(cfg_gain) * 64'(step) * 64'(rng)) >> 16;
            if (allow > 65535) begin
                allow = 65535;
            end
            if (allow == 0) begin
                delta = 0;
            end else if ($urandom_range(15) == 0) begin
                delta = int'(allow) + $urandom_range(1);
            end else begin
                delta = $urandom_range(int'(allow) - 1);
            end
            if ($urandom_range(1) != 0 && rng + delta <= 65535) begin
                rng = rng + delta;
            end else if (rng >= delta) begin
                rng = rng - delta;
            end else begin
                rng = (rng + delta > 65535) ? 65535 : rng + delta;
            end
            add_point(1'b0, beam, 16'(rng), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic fill_phase(input int n_points);
        int target;
        target = items_queued + n_points;
        add_noise_point(1'b1);
        while (items_queued < target) begin
            if ($urandom_range(7) == 0) begin
                add_noise_point($urandom_range(7) == 0);
            end else begin
                add_cluster_run($urandom_range(1, 20));
            end
        end
    endtask

    task automatic wait_until_drained();
        while (beats_accepted != items_queued || emitted_points_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lsbs_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [lsbs_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        if (addr == lsbs_pkg::REG_BREAKPOINT_GAIN) begin
            cfg_gain = data;
        end else if (addr == lsbs_pkg::REG_MIN_CLUSTER_SIZE) begin
            cfg_min_size = data[4:0];
        end
    endtask

    task automatic configure(input logic [15:0] gain, input logic [4:0] min_size);
        write_reg(lsbs_pkg::REG_BREAKPOINT_GAIN, gain);
        write_reg(lsbs_pkg::REG_MIN_CLUSTER_SIZE, {11'($urandom), min_size});
        write_reg(($urandom_range(1) != 0) ? REG_SPARE_3 : REG_SPARE_2, 16'($urandom));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        send_idle_pct = 33;
        recv_idle_pct = 85;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings. The first point has no scan start and is compared with zeros.
        add_point(1'b0, 12'd0, 16'd1000, 16'd0, 16'd0);
        add_point(1'b1, 12'd0, 16'd1000, 16'h7FFF, 16'h8000);
        add_point(1'b0, 12'd1, 16'd1000, 16'h8000, 16'h7FFF);
        add_point(1'b0, 12'd2, 16'd1043, 16'h0001, 16'hFFFF);
        add_point(1'b0, 12'd3, 16'd1043, 16'h5555, 16'hAAAA);
        add_point(1'b0, 12'd4, 16'd1000, 16'hAAAA, 16'h5555);
        add_point(1'b0, 12'd5, 16'd1000, 16'h1234, 16'hFEDC);
        add_point(1'b0, 12'd6, 16'd1046, 16'h0F0F, 16'hF0F0);
        add_point(1'b0, 12'd100, 16'd4096, 16'hFFFF, 16'h0000);
        // The range change lands exactly on the threshold, which counts as a break.
        add_point(1'b0, 12'd116, 16'd6955, 16'h0000, 16'hFFFF);
        add_point(1'b0, 12'd200, 16'd4096, 16'h00FF, 16'hFF00);
        add_point(1'b0, 12'd184, 16'd1238, 16'hFF00, 16'h00FF);
        add_point(1'b0, 12'd184, 16'd1238, 16'h0101, 16'h1010);
        add_point(1'b0, 12'd185, 16'd0, 16'h2020, 16'h0202);
        add_point(1'b0, 12'd186, 16'd0, 16'h3333, 16'hCCCC);
        add_point(1'b0, 12'd4095, 16'd65535, 16'h7FFF, 16'h7FFF);
        add_point(1'b0, 12'd4094, 16'd65535, 16'h8000, 16'h8000);
        add_point(1'b0, 12'd0, 16'd65535, 16'h4444, 16'hBBBB);
        add_point(1'b0, 12'd1, 16'd60000, 16'h6666, 16'h9999);
        add_point(1'b1, 12'd2, 16'd60000, 16'h7777, 16'h8888);
        add_point(1'b0, 12'd3, 16'd60010, 16'h0000, 16'h0000);
        wait_until_drained();

        configure(16'hFFFF, 5'd16);
        fill_phase(35);
        wait_until_drained();

        send_idle_pct = 85;
        recv_idle_pct = 33;
        configure(16'($urandom_range(1000, 20000)), 5'd31);
        fill_phase(35);
        wait_until_drained();

        configure(16'($urandom_range(500, 8000)), 5'($urandom_range(2, 15)));
        fill_phase(25);
        wait_until_drained();

        // Zero gain breaks at every point, so every point opens a new cluster.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(16'd0, 5'd1);
        add_noise_point(1'b1);
        repeat (59) add_noise_point(1'b0);
        hold_request = 1'b1;
        wait_until_drained();

        configure(16'($urandom), 5'd0);
        fill_phase(20);
        wait_until_drained();

        if (mismatch_count == 0 && emitted_points_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
